// File: hdl/dcn_pkg.sv
// ----------------------------------------------------------------------------
// dcn_pkg: shared types and constants of the double classifier
// Holds the class codes, the binary64 field layout and the fixed patterns.
// ----------------------------------------------------------------------------
package dcn_pkg;

  localparam int unsigned ExpW  = 11;
  localparam int unsigned MantW = 52;
  localparam int unsigned ClzW  = 6;   // leading zero count of the mantissa, 0..51
  localparam int unsigned SexpW = 12;

  typedef enum logic [2:0] {
    CLS_ZERO   = 3'd0,
    CLS_SUB    = 3'd1,
    CLS_NORMAL = 3'd2,
    CLS_INF    = 3'd3,
    CLS_NAN    = 3'd4
  } class_e;

  localparam logic [ExpW-1:0]  ExpAllOnes = 11'h7FF;
  localparam logic [ExpW-1:0]  HalfExp    = 11'h3FE;
  localparam logic [63:0]      PatInf     = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0]      PatNan     = 64'h7FFF_0000_0000_0000;
  localparam logic [SexpW-1:0] NormBias   = 12'd1022;
  // A subnormal with its leading one at bit p (p = 51 - clz) has e = -1022 - clz.
  localparam logic [SexpW-1:0] SubBase    = 12'hC02;  // -1022 in 12 bits

  typedef struct packed {
    class_e            cls;
    logic [63:0]       frac;
    logic [SexpW-1:0]  sexp;
  } result_t;

endpackage

// File: hdl/double_classify_normalize_core.sv
// ----------------------------------------------------------------------------
// double_classify_normalize_core: binary64 classifier and frexp normalizer
//
// The input channel carries one binary64 pattern per beat on value_bits_i,
// qualified by in_valid_i and held back by in_stall_o. The output channel
// carries one result per beat: the class code (zero, subnormal, normal,
// infinity, NaN), the fraction as a binary64 pattern with magnitude in
// [0.5, 1) and the signed exponent, so that value = fraction * 2^exponent.
// Zero, infinity and NaN give a fixed unsigned pattern and exponent zero.
//
// Two register stages carry a beat: an input register and a result
// register, with the classify, leading-one search and shift in between.
// A taken beat moves from the input register into the result register, and
// one beat is taken every cycle while the receiver keeps out_stall_i low.
//
// When the receiver stalls, the result register holds its beat and the
// input register still takes one more beat; only when both stages are full
// does in_stall_o rise. Reset empties both stages; the payload registers
// are not cleared since their contents are ignored until a beat is loaded.
// ----------------------------------------------------------------------------
module double_classify_normalize_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [63:0]                    value_bits_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     number_class_o,
  output logic [63:0]                    fraction_bits_o,
  output logic signed [dcn_pkg::SexpW-1:0] scale_exponent_o
);
  import dcn_pkg::*;

  logic        in_vld_q;
  logic [63:0] in_val_q;
  logic        out_vld_q;
  result_t     res_q;
  result_t     res_d;
  logic        out_hold;
  logic        in_hold;

  // The result register holds while its beat waits for the receiver.
  assign out_hold = out_vld_q & out_stall_i;
  // The input register holds only if its beat cannot move on.
  assign in_hold  = in_vld_q & out_hold;
  assign in_stall_o = in_hold;

  dcn_fmt u_fmt (
    .value_i (in_val_q),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_hold) begin
        in_vld_q <= in_valid_i;
      end
      if (!out_hold) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_hold && in_valid_i) begin
      in_val_q <= value_bits_i;
    end
    if (!out_hold && in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign number_class_o   = res_q.cls;
  assign fraction_bits_o  = res_q.frac;
  assign scale_exponent_o = res_q.sexp;

endmodule

// File: hdl/dcn_norm.sv
// ----------------------------------------------------------------------------
// dcn_norm: subnormal mantissa normalizer
// Moves the leading one to the top in six binary shift steps and counts the
// leading zeros on the way.
// ----------------------------------------------------------------------------
module dcn_norm (
  input  logic [dcn_pkg::MantW-1:0] mant_i,
  output logic [dcn_pkg::MantW-1:0] mant_o,
  output logic [dcn_pkg::ClzW-1:0]  clz_o
);
  import dcn_pkg::*;

  logic [MantW-1:0] m0, m1, m2, m3, m4, m5, m6;

  always_comb begin
    m0 = mant_i;
    clz_o = '0;
    m1 = (m0[51:20] == '0) ? {m0[19:0], 32'd0} : m0;
    clz_o[5] = (m0[51:20] == '0);
    m2 = (m1[51:36] == '0) ? {m1[35:0], 16'd0} : m1;
    clz_o[4] = (m1[51:36] == '0);
    m3 = (m2[51:44] == '0) ? {m2[43:0], 8'd0} : m2;
    clz_o[3] = (m2[51:44] == '0);
    m4 = (m3[51:48] == '0) ? {m3[47:0], 4'd0} : m3;
    clz_o[2] = (m3[51:48] == '0);
    m5 = (m4[51:50] == '0) ? {m4[49:0], 2'd0} : m4;
    clz_o[1] = (m4[51:50] == '0);
    m6 = (m5[51] == 1'b0) ? {m5[50:0], 1'b0} : m5;
    clz_o[0] = ~m5[51];
    // The leading one now sits in bit 51 and becomes the hidden bit.
    mant_o = {m6[50:0], 1'b0};
  end

endmodule

// File: hdl/dcn_fmt.sv
// ----------------------------------------------------------------------------
// dcn_fmt: classifier and result assembly
// Decodes the class of a binary64 pattern and builds fraction and exponent.
// ----------------------------------------------------------------------------
module dcn_fmt (
  input  logic [63:0]      value_i,
  output dcn_pkg::result_t res_o
);
  import dcn_pkg::*;

  logic             sign;
  logic [ExpW-1:0]  biased;
  logic [MantW-1:0] mant;
  logic [MantW-1:0] sub_mant;
  logic [ClzW-1:0]  clz;

  assign sign   = value_i[63];
  assign biased = value_i[62:52];
  assign mant   = value_i[51:0];

  dcn_norm u_norm (
    .mant_i (mant),
    .mant_o (sub_mant),
    .clz_o  (clz)
  );

  always_comb begin
    res_o = '{cls: CLS_ZERO, frac: '0, sexp: '0};
    if (biased == ExpAllOnes) begin
      if (mant != '0) begin
        res_o.cls  = CLS_NAN;
        res_o.frac = PatNan;
      end else begin
        res_o.cls  = CLS_INF;
        res_o.frac = PatInf;
      end
    end else if (biased != '0) begin
      res_o.cls  = CLS_NORMAL;
      res_o.frac = {sign, HalfExp, mant};
      res_o.sexp = {1'b0, biased} - NormBias;
    end else if (mant != '0) begin
      res_o.cls  = CLS_SUB;
      res_o.frac = {sign, HalfExp, sub_mant};
      res_o.sexp = SubBase - {{(SexpW-ClzW){1'b0}}, clz};
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the binary64 classifier and normalizer
// Drives raw double patterns into the block and checks class, fraction and
// exponent of every result against a behavioral frexp model. A directed set
// covers the field extremes and the special classes, and a random run
// follows. Both sides of the block idle in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
  import dcn_pkg::*;

  // Exponent offsets: a normal has e = biased - 1022, and a subnormal whose
  // leading mantissa one sits at bit p has e = p - 1073.
  localparam int NormOffset = 1022;
  localparam int SubOffset  = 1073;

  // Number of random beats, and how many of them at the end run with no idling.
  localparam int RandomBeats = 1300;
  localparam int QuietBeats  = 150;

  // Scoreboard: keeps the results expected for accepted input beats in
  // arrival order and checks each output beat against the oldest one.
  class frexp_scoreboard;
    result_t     pending_frexp[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Behavioral frexp of one binary64 pattern.
    function result_t frexp_of(logic [63:0] value);
      logic [ExpW-1:0]  biased;
      logic [MantW-1:0] mant;
      logic [MantW-1:0] shifted;
      int               lead;
      result_t          r;
      biased = value[62:52];
      mant   = value[51:0];
      r.cls  = CLS_ZERO;
      r.frac = '0;
      r.sexp = '0;
      if (biased == ExpAllOnes) begin
        if (mant != '0) begin
          r.cls  = CLS_NAN;
          r.frac = PatNan;
        end else begin
          r.cls  = CLS_INF;
          r.frac = PatInf;
        end
      end else if (biased != '0) begin
        r.cls  = CLS_NORMAL;
        r.sexp = 12'(int'(biased) - NormOffset);
        r.frac = {value[63], HalfExp, mant};
      end else if (mant != '0) begin
        // Ascending scan leaves the highest set bit in lead.
        lead = 0;
        for (int i = 0; i < MantW; i++) begin
          if (mant[i]) lead = i;
        end
        // The leading one lands on bit 52 and falls off as the hidden bit.
        shifted = mant << (MantW - lead);
        r.cls   = CLS_SUB;
        r.sexp  = 12'(lead - SubOffset);
        r.frac  = {value[63], HalfExp, shifted};
      end
      return r;
    endfunction

    function void note_value(logic [63:0] value);
      pending_frexp.push_back(frexp_of(value));
    endfunction

    function void check_result(logic [2:0] cls, logic [63:0] frac, logic [11:0] sexp);
      result_t want;
      if (pending_frexp.size() == 0) begin
        $display("%0t: unexpected result beat: class %0d fraction %h exponent %0d",
                 $time, cls, frac, $signed(sexp));
        mismatches++;
        return;
      end
      want = pending_frexp.pop_front();
      if (cls !== want.cls) begin
        $display("%0t: number_class expected %0d actual %0d", $time, want.cls, cls);
        mismatches++;
      end
      if (frac !== want.frac) begin
        $display("%0t: fraction_bits expected %h actual %h", $time, want.frac, frac);
        mismatches++;
      end
      if (sexp !== want.sexp) begin
        $display("%0t: scale_exponent expected %0d actual %0d",
                 $time, $signed(want.sexp), $signed(sexp));
        mismatches++;
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [63:0]             value_bits_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [2:0]              number_class_o;
  logic [63:0]             fraction_bits_o;
  logic signed [SexpW-1:0] scale_exponent_o;

  frexp_scoreboard frexp_sb = new();

  // Set for the final stretch of the run, where neither side idles.
  bit quiet_tail;
  // Set while the sender is in a bursty stretch; cleared gives back-to-back beats.
  bit bursty_sender;

  double_classify_normalize_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .value_bits_i     (value_bits_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .number_class_o   (number_class_o),
    .fraction_bits_o  (fraction_bits_o),
    .scale_exponent_o (scale_exponent_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Receiver stall pattern: stall bursts alternate with free runs, both of
  // random length. The run lengths are drawn per burst so that stalls hit
  // every phase of the two-stage pipeline, including the cycle where the
  // input register fills behind a held result.
  int  stall_left;
  bit  stall_now;
  always @(posedge clk_i) begin
    if (!rst_ni || quiet_tail) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      stall_now   <= 1'b0;
    end else if (stall_left == 0) begin
      // Start a new run; the opposite kind of the one just finished. The
      // starting cycle is part of the run, so the count covers the rest.
      stall_now   <= !stall_now;
      stall_left  <= stall_now ? $urandom_range(0, 39) : $urandom_range(0, 10);
      out_stall_i <= !stall_now;
    end else begin
      stall_left  <= stall_left - 1;
      out_stall_i <= stall_now;
    end
  end

  // Output monitor. Values are read in the active region right after the
  // edge, so they are the ones the block saw at that edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      frexp_sb.check_result(number_class_o, fraction_bits_o, scale_exponent_o);
    end
  end

  // Hand one beat to the block and hold it until accepted. On return the
  // current step is the accepting edge; valid stays high so a following
  // beat can be driven in the same step without dropping it.
  task automatic send_beat(input logic [63:0] value);
    in_valid_i   <= 1'b1;
    value_bits_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    frexp_sb.note_value(value);
  endtask

  // Sender gap: valid low for a burst of cycles, with junk on the data bus.
  task automatic sender_gap();
    in_valid_i   <= 1'b0;
    value_bits_i <= {$urandom, $urandom};
    repeat ($urandom_range(1, 11)) @(posedge clk_i);
  endtask

  // Random binary64 pattern, weighted toward the interesting classes.
  // Subnormals pick the leading-one position uniformly so every shift
  // amount of the normalizer is exercised.
  function automatic logic [63:0] random_double();
    logic [63:0] raw;
    logic [51:0] mant;
    logic        sgn;
    int          lead;
    int          pick;
    raw  = {$urandom, $urandom};
    mant = raw[51:0];
    sgn  = raw[63];
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        // Zero, infinity or NaN of either sign.
        case ($urandom_range(0, 2))
          0:       return {sgn, 11'h000, 52'h0};
          1:       return {sgn, ExpAllOnes, 52'h0};
          default: return {sgn, ExpAllOnes, (mant == '0) ? 52'h1 : mant};
        endcase
      end
      1, 2, 3: begin
        lead = $urandom_range(0, 51);
        mant = (mant & ((52'h1 << lead) - 52'h1)) | (52'h1 << lead);
        return {sgn, 11'h000, mant};
      end
      4, 5, 6, 7: begin
        // Mostly anywhere in range, sometimes at the ends of the exponent.
        case ($urandom_range(0, 5))
          0:       return {sgn, 11'h001, mant};
          1:       return {sgn, 11'h7FE, mant};
          default: return {sgn, 11'($urandom_range(1, 2046)), mant};
        endcase
      end
      default: return raw;
    endcase
  endfunction

  // Directed beats: signed zeros, infinities, quiet and signaling NaNs,
  // the subnormal extremes and leading-one positions, normal extremes.
  logic [63:0] directed_values[$] = '{
    64'h0000_0000_0000_0000,  // +0
    64'h8000_0000_0000_0000,  // -0
    64'h7FF0_0000_0000_0000,  // +inf
    64'hFFF0_0000_0000_0000,  // -inf
    64'h7FF8_0000_0000_0000,  // quiet NaN
    64'h7FF0_0000_0000_0001,  // signaling NaN, smallest payload
    64'hFFFF_FFFF_FFFF_FFFF,  // negative NaN, all ones
    64'h0000_0000_0000_0001,  // smallest subnormal, leading one at bit 0
    64'h8000_0000_0000_0001,  // negative smallest subnormal
    64'h000F_FFFF_FFFF_FFFF,  // largest subnormal
    64'h800F_FFFF_FFFF_FFFF,  // negative largest subnormal
    64'h0008_0000_0000_0000,  // subnormal, leading one at the top bit
    64'h0000_0001_0000_0000,  // subnormal, leading one mid mantissa
    64'h0000_0000_8000_0001,  // subnormal, bits below the leading one
    64'h0005_5555_5555_5555,  // subnormal, alternating bits
    64'h0010_0000_0000_0000,  // smallest normal
    64'h8010_0000_0000_0000,  // negative smallest normal
    64'h7FEF_FFFF_FFFF_FFFF,  // largest normal
    64'hFFEF_FFFF_FFFF_FFFF,  // negative largest normal
    64'h3FF0_0000_0000_0000,  // 1.0
    64'hBFF0_0000_0000_0000,  // -1.0
    64'h3FE0_0000_0000_0000,  // 0.5, exponent zero
    64'h7FFA_AAAA_AAAA_AAAA   // NaN with mixed payload
  };

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    value_bits_i  = '0;
    out_stall_i   = 1'b0;
    quiet_tail    = 1'b0;
    bursty_sender = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_values[i]) begin
      send_beat(directed_values[i]);
      if ($urandom_range(0, 3) == 0) sender_gap();
    end

    for (int n = 0; n < RandomBeats; n++) begin
      // Every 64 beats decide whether the sender idles at all.
      if (n % 64 == 0) bursty_sender = ($urandom_range(0, 2) != 0);
      if (n == RandomBeats - QuietBeats) quiet_tail = 1'b1;
      send_beat(random_double());
      if (!quiet_tail && bursty_sender && $urandom_range(0, 3) == 0) sender_gap();
    end
    in_valid_i <= 1'b0;

    // Drain: wait for every expected result, then a few cycles more so a
    // stray extra beat from the two-stage pipeline would still be seen.
    while (frexp_sb.pending_frexp.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (frexp_sb.mismatches == 0 && frexp_sb.pending_frexp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
